>>> sv/lzf_pkg.sv
`default_nettype none
package lzf_pkg;
    localparam int HIST_DEPTH = 8192;
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int OUT_BYTES = 8;
    localparam int POS_W = 21;
    localparam int CNT_W = 9;
    localparam logic [POS_W-1:0] MAX_OUTPUT = 21'd1048576;
    localparam logic [POS_W-1:0] LIMIT_RESET = 21'd16384;
    localparam logic [7:0] LITERAL_BOUND = 8'd32;
    localparam logic [CNT_W-1:0] LEN_EXTEND_CODE = 9'd6;
    localparam logic [CNT_W-1:0] MIN_COPY = 9'd3;
    localparam logic [3:0] WORD_FULL = 4'(OUT_BYTES);

    typedef enum logic [1:0] {
        PH_CONTROL,
        PH_LITERAL,
        PH_EXTEND,
        PH_DISTANCE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic rd;
        logic wr;
        logic put;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic copy_go;
        logic word_last;
        logic cnt_zero;
    } status_t;
endpackage
`default_nettype wire

>>> sv/lzf_ctrl.sv
`default_nettype none
module lzf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire lzf_pkg::status_t sts,
    output lzf_pkg::cmd_t        cmd
);
    import lzf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.out_free && sts.copy_go)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = sts.word_last ? ST_PUT : ST_READ;
            ST_PUT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.cnt_zero ? ST_IDLE : ST_READ;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready  = sts.out_free;
                cmd.accept = in_valid && sts.out_free;
            end
            ST_READ:  cmd.rd = 1'b1;
            ST_WRITE: cmd.wr = 1'b1;
            ST_PUT:   cmd.put = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> $past(cmd.rd))
        else $error("write without read");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (cmd.ready || cmd.rd || !sts.out_free))
        else $error("bad state after accept");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.rd, cmd.wr, cmd.put}))
        else $error("overlapping commands");
endmodule
`default_nettype wire

>>> sv/lzf_datapath.sv
`default_nettype none
module lzf_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lzf_pkg::cmd_t            cmd,
    output lzf_pkg::status_t              sts,
    input  wire logic                     cfg_valid,
    input  wire logic [lzf_pkg::POS_W-1:0] cfg_data,
    input  wire logic [7:0]               in_byte,
    input  wire logic                     in_last,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic [63:0]                   out_data,
    output logic [3:0]                    out_count,
    output logic                          out_end,
    output logic                          out_failed,
    output logic [lzf_pkg::POS_W-1:0]     out_total
);
    import lzf_pkg::*;

    logic [7:0] hist [HIST_DEPTH];
    logic [7:0] rdata_reg;

    logic [POS_W-1:0] limit_reg, pos_reg, pos_next;
    phase_t phase_reg, phase_next;
    logic [4:0] lit_reg, lit_next, dhi_reg, dhi_next;
    logic [CNT_W-1:0] clen_reg, clen_next, cnt_reg, cnt_next;
    logic err_reg, err_next, last_reg, last_next;
    logic fin_reg, fin_next;
    logic [13:0] dist_reg, dist_next;
    logic [63:0] w_reg, w_next;
    logic [3:0] k_reg, k_next;

    logic ov_reg, ov_next, oe_reg, oe_next, of_reg, of_next;
    logic [63:0] od_reg, od_next;
    logic [3:0] oc_reg, oc_next;
    logic [POS_W-1:0] ot_reg, ot_next;

    logic we, copy_go;
    logic [HIST_AW-1:0] waddr, raddr;
    logic [7:0] wdata;
    logic [POS_W-1:0] lim;
    logic [POS_W:0] lit_sum, copy_sum;
    logic [13:0] dist_c;
    logic [CNT_W-1:0] cnt_c;
    logic out_free, lit_out, load_end;

    assign out_free = !ov_reg || out_ready;
    assign lim = (limit_reg > MAX_OUTPUT) ? MAX_OUTPUT : limit_reg;
    assign lit_sum = {1'b0, pos_reg} + (POS_W+1)'(in_byte) + (POS_W+1)'(1);
    assign dist_c = {dhi_reg, in_byte} + 14'd1;
    assign cnt_c = clen_reg + MIN_COPY;
    assign copy_sum = {1'b0, pos_reg} + (POS_W+1)'(cnt_c);
    assign copy_go = !err_reg && phase_reg == PH_DISTANCE
        && !(copy_sum > {1'b0, lim}) && !((POS_W)'(dist_c) > pos_reg);
    assign raddr = HIST_AW'(pos_reg - POS_W'(dist_reg));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= hist[raddr];
        end
    end

    always_comb
    begin
        pos_next = pos_reg; phase_next = phase_reg; lit_next = lit_reg;
        dhi_next = dhi_reg; clen_next = clen_reg; cnt_next = cnt_reg;
        err_next = err_reg; last_next = last_reg; dist_next = dist_reg;
        fin_next = fin_reg;
        w_next = w_reg; k_next = k_reg;
        ov_next = ov_reg && !out_ready;
        od_next = od_reg; oc_next = oc_reg; oe_next = oe_reg;
        of_next = of_reg; ot_next = ot_reg;
        we = 1'b0; waddr = HIST_AW'(pos_reg); wdata = in_byte;
        lit_out = 1'b0; load_end = 1'b0;
        if (cmd.accept)
        begin
            if (!err_reg)
            begin
                unique case (phase_reg)
                    PH_CONTROL:
                    begin
                        if (in_byte < LITERAL_BOUND)
                        begin
                            if (lit_sum > {1'b0, lim})
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                lit_next = in_byte[4:0];
                                phase_next = PH_LITERAL;
                            end
                        end
                        else
                        begin
                            clen_next = CNT_W'(in_byte[7:5]) - 9'd1;
                            dhi_next = in_byte[4:0];
                            phase_next = (clen_next == LEN_EXTEND_CODE)
                                ? PH_EXTEND : PH_DISTANCE;
                        end
                    end
                    PH_LITERAL:
                    begin
                        we = 1'b1;
                        pos_next = pos_reg + 21'd1;
                        lit_out = 1'b1;
                        if (lit_reg == 5'd0)
                        begin
                            phase_next = PH_CONTROL;
                        end
                        else
                        begin
                            lit_next = lit_reg - 5'd1;
                        end
                    end
                    PH_EXTEND:
                    begin
                        clen_next = clen_reg + CNT_W'(in_byte);
                        phase_next = PH_DISTANCE;
                    end
                    PH_DISTANCE:
                    begin
                        phase_next = PH_CONTROL;
                        if (copy_go)
                        begin
                            dist_next = dist_c;
                            cnt_next = cnt_c;
                            last_next = in_last;
                            w_next = '0;
                            k_next = '0;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    default: phase_next = PH_CONTROL;
                endcase
            end
            if (in_last && !copy_go)
            begin
                if (!err_next && phase_next != PH_CONTROL)
                begin
                    err_next = 1'b1;
                end
                load_end = 1'b1;
            end
            if (lit_out || load_end)
            begin
                // a run cut short: literal word now, failure word next
                ov_next = 1'b1;
                od_next = lit_out ? {56'd0, in_byte} : '0;
                oc_next = lit_out ? 4'd1 : 4'd0;
                oe_next = load_end && !(lit_out && err_next);
                of_next = load_end && !lit_out && err_next;
                ot_next = (load_end && !err_next) ? pos_next : '0;
                fin_next = lit_out && load_end && err_next;
            end
            if (load_end)
            begin
                pos_next = '0; phase_next = PH_CONTROL; lit_next = '0;
                clen_next = '0; dhi_next = '0; err_next = 1'b0;
            end
        end
        if (cmd.wr)
        begin
            we = 1'b1;
            wdata = rdata_reg;
            pos_next = pos_reg + 21'd1;
            cnt_next = cnt_reg - 9'd1;
            w_next[8*k_reg[2:0] +: 8] = rdata_reg;
            k_next = k_reg + 4'd1;
        end
        if (cmd.put)
        begin
            ov_next = 1'b1;
            od_next = w_reg;
            oc_next = k_reg;
            oe_next = last_reg && cnt_reg == '0;
            of_next = 1'b0;
            ot_next = oe_next ? pos_reg : '0;
            w_next = '0;
            k_next = '0;
            if (oe_next)
            begin
                pos_next = '0; phase_next = PH_CONTROL; lit_next = '0;
                clen_next = '0; dhi_next = '0; err_next = 1'b0; last_next = 1'b0;
            end
        end
        if (fin_reg && out_free)
        begin
            ov_next = 1'b1;
            od_next = '0;
            oc_next = 4'd0;
            oe_next = 1'b1;
            of_next = 1'b1;
            ot_next = '0;
            fin_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            pos_reg <= '0; phase_reg <= PH_CONTROL; lit_reg <= '0;
            dhi_reg <= '0; clen_reg <= '0; cnt_reg <= '0; err_reg <= 1'b0;
            last_reg <= 1'b0; ov_reg <= 1'b0; k_reg <= '0; w_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            pos_reg <= pos_next; phase_reg <= phase_next; lit_reg <= lit_next;
            dhi_reg <= dhi_next; clen_reg <= clen_next; cnt_reg <= cnt_next;
            err_reg <= err_next; last_reg <= last_next; ov_reg <= ov_next;
            k_reg <= k_next; w_reg <= w_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        od_reg <= od_next; oc_reg <= oc_next; oe_reg <= oe_next;
        of_reg <= of_next; ot_reg <= ot_next;
    end

    assign sts.out_free = out_free && !fin_reg;
    assign sts.copy_go = copy_go;
    assign sts.word_last = (k_reg == WORD_FULL - 4'd1) || (cnt_reg == 9'd1);
    assign sts.cnt_zero = (cnt_reg == '0);

    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign out_count = oc_reg;
    assign out_end = oe_reg;
    assign out_failed = of_reg;
    assign out_total = ot_reg;

    a_put_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> k_reg != 4'd0)
        else $error("empty copy word");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (cnt_reg != '0 && cnt_reg <= 9'd264))
        else $error("copy count out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)
            && $stable(out_count) && $stable(out_end)))
        else $error("output word changed while stalled");
    a_fin_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !cmd.accept)
        else $error("input taken while failure word pending");
endmodule
`default_nettype wire

>>> sv/lzf_stream_decompressor_unit.sv
`default_nettype none
// LZF decompressor: one compressed byte per input word.
// Literal and control bytes are taken while the output is free; a literal lands in the output register next cycle.
// Back reference: each copied byte is read then written, and each packed output word is put; input stalls meanwhile.
// A literal run cut short by tlast sends a separate failure word after its literal word.
// rst_n (async, active low) clears stream state and sets output_limit to 16384;
// the history RAM is not cleared.
module lzf_stream_decompressor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [20:0] cfg_data,     // output_limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // in_byte
    input  wire logic        s_tlast,      // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,      // out_data[63:0], out_count[67:64], total_length[88:68]
    output logic             m_tlast,      // stream_end
    output logic             m_tuser       // failed
);
    import lzf_pkg::*;

    cmd_t cmd;
    status_t sts;
    logic [63:0] out_data;
    logic [3:0] out_count;
    logic [POS_W-1:0] out_total;

    assign cfg_ready = 1'b1;
    assign s_tready = cmd.ready;

    lzf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .sts(sts), .cmd(cmd)
    );

    lzf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .in_byte(s_tdata), .in_last(s_tlast),
        .out_ready(m_tready), .out_valid(m_tvalid),
        .out_data(out_data), .out_count(out_count),
        .out_end(m_tlast), .out_failed(m_tuser), .out_total(out_total)
    );

    assign m_tdata = {7'd0, out_total, out_count, out_data};
endmodule
`default_nettype wire
